// ----- rtl/sbn_pkg.sv -----
// Shared constants for the slice bounds normalizer.
package sbn_pkg;

  // Default width of index, stride and length values
  localparam int INDEX_WIDTH_DEF = 32;

  // Lowest bound used for a negative stride
  localparam int NEG_LOW = -1;

endpackage

// ----- rtl/sbn_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side data carried along.
module sbn_divider
  import sbn_pkg::*;
#(
  parameter int WIDTH  = INDEX_WIDTH_DEF,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [WIDTH-2:0]  dividend,
  input  logic [WIDTH-1:0]  divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [WIDTH-2:0]  quotient,
  output logic [SIDE_W-1:0] side_out
);

  localparam int N = WIDTH - 1;

  logic              vld  [0:N];
  logic [N-1:0]      num  [0:N];
  logic [N-1:0]      quo  [0:N];
  logic [N-1:0]      rem  [0:N];
  logic [WIDTH-1:0]  dvs  [0:N];
  logic [SIDE_W-1:0] side [0:N];

  // stage 0 is the incoming item
  assign vld[0]  = in_valid;
  assign num[0]  = dividend;
  assign quo[0]  = '0;
  assign rem[0]  = '0;
  assign dvs[0]  = divisor;
  assign side[0] = side_in;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [WIDTH-1:0] trial;
    logic [WIDTH-1:0] diff;
    logic             fits;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem[k], num[k][N-1]};
    assign diff  = trial - dvs[k];
    assign fits  = (trial >= dvs[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= fits ? diff[N-1:0] : trial[N-1:0];
        num[k+1]  <= num[k] << 1;
        quo[k+1]  <= {quo[k][N-2:0], fits};
        dvs[k+1]  <= dvs[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign quotient  = quo[N];
  assign side_out  = side[N];

endmodule

// ----- rtl/slice_bounds_normalizer_core.sv -----
// Slice bounds normalizer top level: bound placement, span setup, divider and output register.
// The pipeline depth is set by the one-bit-per-stage divider.
// Throughput: one item per cycle while the output is not stalled.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset (rst, synchronous, active high) clears all valid bits; payload is not reset.
module slice_bounds_normalizer_core
  import sbn_pkg::*;
#(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  // slave side
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  // seq_length, start_value, stop_value, step_value, zero pad
  input  logic [((4*INDEX_WIDTH-1+7)/8)*8-1:0]         s_tdata,
  // start_present, stop_present, step_present
  input  logic [2:0]                                   s_tuser,
  // master side
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // first_index, end_index, stride, element_count, zero pad
  output logic [((4*INDEX_WIDTH-1+7)/8)*8-1:0]         m_tdata,
  // step_error
  output logic                                         m_tuser
);

  localparam int W      = INDEX_WIDTH;
  localparam int DATA_W = ((4*W-1+7)/8)*8;
  localparam int SIDE_W = 3*W + 2;

  typedef logic signed [W-1:0] idx_t;

  localparam idx_t LOW_NEG = idx_t'(NEG_LOW);

  logic adv;

  // input fields
  logic [W-2:0] seq_length;
  idx_t         start_value, stop_value, step_value;
  logic         start_present, stop_present, step_present;

  assign seq_length    = s_tdata[W-2:0];
  assign start_value   = s_tdata[2*W-2:W-1];
  assign stop_value    = s_tdata[3*W-2:2*W-1];
  assign step_value    = s_tdata[4*W-2:3*W-1];
  assign start_present = s_tuser[0];
  assign stop_present  = s_tuser[1];
  assign step_present  = s_tuser[2];

  // whole pipeline moves when the output slot frees up
  assign adv      = m_tready || !m_tvalid;
  assign s_tready = adv;

  // offset a negative index by the length, then clamp
  function automatic idx_t place_index(idx_t idx, idx_t len, idx_t lo, idx_t hi);
    idx_t t;
    t = idx + len;
    if (idx < 0) begin
      place_index = (t < lo) ? lo : t;
    end else begin
      place_index = (idx > hi) ? hi : idx;
    end
  endfunction

  // stage 1: defaults and bound placement
  idx_t len_s, step_c, low_c, high_c, first_c, end_c;
  logic neg_c;

  always_comb begin
    len_s   = idx_t'({1'b0, seq_length});
    step_c  = step_present ? step_value : idx_t'(1);
    neg_c   = step_c[W-1];
    low_c   = neg_c ? LOW_NEG : '0;
    high_c  = neg_c ? (len_s - idx_t'(1)) : len_s;
    first_c = neg_c ? high_c : low_c;
    end_c   = neg_c ? low_c : high_c;
    if (start_present) begin
      first_c = place_index(start_value, len_s, low_c, high_c);
    end
    if (stop_present) begin
      end_c = place_index(stop_value, len_s, low_c, high_c);
    end
  end

  logic s1_valid;
  idx_t s1_first, s1_end, s1_step;
  logic s1_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first <= first_c;
      s1_end   <= end_c;
      s1_step  <= step_c;
      s1_neg   <= neg_c;
    end
  end

  // stage 2: span, emptiness and stride magnitude
  idx_t span_c;
  logic nonempty_c, zero_c;

  always_comb begin
    span_c     = s1_neg ? (s1_first - s1_end - idx_t'(1)) : (s1_end - s1_first - idx_t'(1));
    nonempty_c = s1_neg ? (s1_end < s1_first) : (s1_first < s1_end);
    zero_c     = (s1_step == '0);
  end

  logic              s2_valid;
  logic [W-2:0]      s2_dividend;
  logic [W-1:0]      s2_divisor;
  logic [SIDE_W-1:0] s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_dividend <= span_c[W-2:0];
      s2_divisor  <= s1_neg ? (~s1_step + 1'b1) : s1_step;
      s2_side     <= {zero_c, nonempty_c && !zero_c, s1_step, s1_end, s1_first};
    end
  end

  // count = span / |step| + 1 for a nonempty slice with nonzero step, else zero
  logic              div_valid;
  logic [W-2:0]      div_quo;
  logic [SIDE_W-1:0] div_side;

  sbn_divider #(
    .WIDTH  (W),
    .SIDE_W (SIDE_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s2_valid),
    .dividend  (s2_dividend),
    .divisor   (s2_divisor),
    .side_in   (s2_side),
    .out_valid (div_valid),
    .quotient  (div_quo),
    .side_out  (div_side)
  );

  // output register
  logic [W-2:0]      count_c;
  logic [DATA_W-1:0] out_c;

  always_comb begin
    count_c = div_side[3*W] ? (div_quo + 1'b1) : '0;
    out_c   = '0;
    out_c[4*W-2:0] = {count_c, div_side[3*W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= out_c;
      m_tuser <= div_side[3*W+1];
    end
  end

endmodule

// ----- sim/sbn_result_checker.sv -----
// Result checker for the slice bounds normalizer: watches both streams, predicts and compares.
module sbn_result_checker
  import sbn_pkg::*;
#(
  parameter int DW = ((4*INDEX_WIDTH_DEF-1+7)/8)*8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tready,
  input  logic [DW-1:0] s_tdata,   // seq_length, start_value, stop_value, step_value, pad
  input  logic [2:0]    s_tuser,   // start_present, stop_present, step_present
  input  logic          m_tvalid,
  input  logic          m_tready,
  input  logic [DW-1:0] m_tdata,   // first_index, end_index, stride, element_count, pad
  input  logic          m_tuser,   // step_error
  output int            fail_count,
  output int            pending
);

  localparam int USER_START = 0;
  localparam int USER_STOP  = 1;
  localparam int USER_STEP  = 2;

  typedef struct packed {
    logic [31:0] first_index;
    logic [31:0] end_index;
    logic [31:0] stride;
    logic [30:0] element_count;
    logic        step_error;
  } slice_bounds_t;

  slice_bounds_t expected_bounds_q[$];
  int            result_num = 0;

  // Offset a negative index by the length, then clamp into [low, high]
  function automatic longint place_bound(input longint idx, input longint length,
                                         input longint low, input longint high);
    if (idx < 0) begin
      idx = idx + length;
      if (idx < low) idx = low;
    end else if (idx > high) begin
      idx = high;
    end
    return idx;
  endfunction

  // Normalize one slice request
  function automatic slice_bounds_t normalize_slice(input logic [30:0] len,
                                                    input logic [2:0]  flags,
                                                    input logic [31:0] start_raw,
                                                    input logic [31:0] stop_raw,
                                                    input logic [31:0] step_raw);
    longint        length, step, low, high, first, stop_idx, count;
    slice_bounds_t r;
    length = {33'b0, len};
    step   = 1;
    count  = 0;
    if (flags[USER_STEP]) step = $signed(step_raw);
    // bounds and defaults follow the walk direction
    if (step < 0) begin
      low      = NEG_LOW;
      high     = length - 1;
      first    = high;
      stop_idx = low;
    end else begin
      low      = 0;
      high     = length;
      first    = low;
      stop_idx = high;
    end
    if (flags[USER_START]) first    = place_bound($signed(start_raw), length, low, high);
    if (flags[USER_STOP])  stop_idx = place_bound($signed(stop_raw), length, low, high);
    // signed ceiling of span over step
    if (step < 0) begin
      if (stop_idx < first) count = (first - stop_idx - 1) / (-step) + 1;
    end else if (step > 0) begin
      if (first < stop_idx) count = (stop_idx - first - 1) / step + 1;
    end
    r.first_index   = first[31:0];
    r.end_index     = stop_idx[31:0];
    r.stride        = step[31:0];
    r.element_count = count[30:0];
    r.step_error    = (step == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    if (got != want) begin
      $display("result %0d: %s is %0d, expected %0d", result_num, field, got, want);
      fail_count = fail_count + 1;
    end
  endtask

  // Predict on input accept, compare on output accept
  always @(posedge clk) begin
    slice_bounds_t want;
    if (rst) begin
      expected_bounds_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_bounds_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_bounds_q.pop_front();
          report_mismatch("first_index", $signed(m_tdata[31:0]), $signed(want.first_index));
          report_mismatch("end_index", $signed(m_tdata[63:32]), $signed(want.end_index));
          report_mismatch("stride", $signed(m_tdata[95:64]), $signed(want.stride));
          report_mismatch("element_count", m_tdata[126:96], want.element_count);
          report_mismatch("step_error", m_tuser, want.step_error);
        end
        result_num = result_num + 1;
      end
      if (s_tvalid && s_tready)
        expected_bounds_q.push_back(normalize_slice(s_tdata[30:0], s_tuser, s_tdata[62:31],
                                                    s_tdata[94:63], s_tdata[126:95]));
    end
    pending <= expected_bounds_q.size();
  end

endmodule

// ----- sim/tb_slice_bounds_normalizer_core.sv -----
// Testbench top for the slice bounds normalizer: stimulus, stream pacing and verdict.
module tb_slice_bounds_normalizer_core
  import sbn_pkg::*;
();

  localparam int DW          = ((4*INDEX_WIDTH_DEF-1+7)/8)*8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int ITEMS_PER_PHASE = 130;
  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7fff_ffff;
  localparam logic [30:0] MAX_LEN  = 31'h7fff_ffff;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [DW-1:0] s_tdata = '0;   // seq_length, start_value, stop_value, step_value, pad
  logic [2:0]    s_tuser = '0;   // start_present, stop_present, step_present
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [DW-1:0] m_tdata;        // first_index, end_index, stride, element_count, pad
  logic          m_tuser;        // step_error

  int fail_count;
  int pending;
  int tx_idle_pct = 13;
  int rx_idle_pct = 56;
  bit hold_req    = 1'b0;
  int hold_count  = 0;
  int cycle_count = 0;

  slice_bounds_normalizer_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  sbn_result_checker #(.DW(DW)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver pacing, with one long hold-off when requested
  always @(posedge clk) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      m_tready   <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one request and wait until it is taken; random gaps go before it
  task automatic send_slice(input logic [30:0] len, input logic [2:0] flags,
                            input logic [31:0] start_v, input logic [31:0] stop_v,
                            input logic [31:0] step_v);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, step_v, stop_v, start_v, len};
    s_tuser  <= flags;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [30:0] rand_length();
    case ($urandom_range(9))
      7:       return 31'($urandom);
      8:       return MAX_LEN;
      9:       return '0;
      default: return 31'($urandom_range(20));
    endcase
  endfunction

  function automatic logic [31:0] rand_index(input logic [30:0] len);
    case ($urandom_range(9))
      6:       return $urandom;
      7:       return MOST_NEG;
      8:       return MOST_POS;
      9:       return $urandom_range(1) ? {1'b0, len} + $urandom_range(2) - 1
                                        : -{1'b0, len} + $urandom_range(2) - 1;
      default: return $urandom_range(60) - 30;
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(11))
      6:       return '0;
      7, 8:    return $urandom;
      9:       return MOST_NEG;
      10:      return MOST_POS;
      11:      return -32'($urandom_range(4, 1));
      default: return $urandom_range(1) ? 32'($urandom_range(4, 1))
                                        : -32'($urandom_range(4, 1));
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic [30:0] len;
    logic [2:0]  flags;
    for (int i = 0; i < count; i++) begin
      len   = rand_length();
      flags = {($urandom_range(4) != 0), 2'($urandom)};
      send_slice(len, flags, rand_index(len), rand_index(len), rand_step());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: defaults, clamping, zero and extreme steps, extreme lengths
    send_slice(31'd0,  3'b000, 32'd0, 32'd0, 32'd0);
    send_slice(31'd10, 3'b000, 32'd0, 32'd0, 32'd0);
    send_slice(31'd10, 3'b100, 32'd0, 32'd0, -32'd1);
    send_slice(31'd10, 3'b111, -32'd3, -32'd1, 32'd1);
    send_slice(31'd10, 3'b111, -32'd100, 32'd100, 32'd1);
    send_slice(31'd10, 3'b111, 32'd100, -32'd100, -32'd1);
    send_slice(31'd10, 3'b111, 32'd3, 32'd3, 32'd0);
    send_slice(31'd10, 3'b100, 32'd0, 32'd0, 32'd0);
    send_slice(MAX_LEN, 3'b111, 32'd0, MOST_POS, MOST_NEG);
    send_slice(MAX_LEN, 3'b100, 32'd0, 32'd0, MOST_NEG);
    send_slice(MAX_LEN, 3'b101, -32'd1, 32'd0, MOST_NEG);
    send_slice(MAX_LEN, 3'b100, 32'd0, 32'd0, MOST_POS);
    send_slice(MAX_LEN, 3'b011, MOST_NEG, MOST_POS, 32'd0);
    send_slice(31'd5,  3'b111, MOST_POS, MOST_NEG, -32'd1);
    send_slice(31'd7,  3'b111, 32'd1, 32'd6, 32'd2);
    send_slice(31'd7,  3'b111, 32'd6, 32'd1, -32'd2);
    send_slice(31'd0,  3'b111, -32'd1, 32'd1, -32'd1);
    send_slice(31'd10, 3'b010, 32'd0, -32'd4, 32'd0);
    send_slice(31'd10, 3'b001, 32'd12, 32'd0, 32'd0);
    send_slice(31'd1,  3'b111, -32'd1, -32'd2, -32'd1);
    send_slice(31'h4000_0000, 3'b111, 32'h5555_5555, 32'hAAAA_AAAA, 32'd3);

    random_phase(ITEMS_PER_PHASE);

    tx_idle_pct <= 56;
    rx_idle_pct <= 13;
    random_phase(ITEMS_PER_PHASE);

    // no idling; the receiver stalls long enough to back up the pipeline
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    hold_req    <= 1'b1;
    random_phase(ITEMS_PER_PHASE);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
